[hw/rtl/acsc_pkg.sv]
// Shared constants, codes and types for the ADC channel averaging scanner.
`timescale 1ns / 1ps

package acsc_pkg;

    localparam int ACSC_NUM_CHANNELS = 4;
    localparam int ACSC_AVG_COUNT    = 256;
    localparam int ACSC_SAMPLE_BITS  = 10;

    localparam int OP_W    = 2;
    localparam int VALUE_W = 16;

    localparam logic [VALUE_W-1:0] NO_RESULT = 16'hFFFF;

    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_W-1:0] OP_START  = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP   = 2'd2;

    typedef logic evt_kind_t;
    localparam evt_kind_t EVT_AVG  = 1'b0;
    localparam evt_kind_t EVT_STOP = 1'b1;

endpackage

[hw/rtl/acsc_in_if.sv]
// Input word channel: command code and conversion sample.
`timescale 1ns / 1ps

interface acsc_in_if #(
    parameter int SAMPLE_BITS = acsc_pkg::ACSC_SAMPLE_BITS
);
    logic                      valid;
    logic                      ready;
    logic [acsc_pkg::OP_W-1:0] op;
    logic [SAMPLE_BITS-1:0]    sample;

    modport source (output valid, output op, output sample, input ready);
    modport sink   (input valid, input op, input sample, output ready);
endinterface

[hw/rtl/acsc_out_if.sv]
// Result word channel: channel, value, next channel and last flag.
`timescale 1ns / 1ps

interface acsc_out_if #(
    parameter int CH_W = 2
);
    logic                         valid;
    logic                         ready;
    logic [CH_W-1:0]              channel;
    logic [acsc_pkg::VALUE_W-1:0] value;
    logic [CH_W-1:0]              next_channel;
    logic                         last;

    modport source (output valid, output channel, output value, output next_channel,
                    output last, input ready);
    modport sink   (input valid, input channel, input value, input next_channel,
                    input last, output ready);
endinterface

[hw/rtl/adc_channel_averaging_scanner.sv]
// Top level of the round-robin ADC scanner with block averaging.
//
//  channel   dir  handshake     payload
//  item      in   valid/ready   op, sample
//  result    out  valid/ready   channel, value, next_channel, last
//  cfg       in   cfg_write     cfg_data (channel enable mask)
//
// One input word per cycle while item.ready is high. An average reaches the output
// register from the sample that closes the block via the event register, then the divide.
// A stop fills the output with one word per enabled channel; the input stalls
// once the event register holds it. Reset clears sum, count, selection and enables.
// item.ready falls only while the event register is full and cannot drain.
`timescale 1ns / 1ps

module adc_channel_averaging_scanner #(
    parameter int NUM_CHANNELS = acsc_pkg::ACSC_NUM_CHANNELS,
    parameter int AVG_COUNT    = acsc_pkg::ACSC_AVG_COUNT,
    parameter int SAMPLE_BITS  = acsc_pkg::ACSC_SAMPLE_BITS,
    localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
    localparam int SUM_W = SAMPLE_BITS + $clog2(AVG_COUNT)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    acsc_in_if.sink                 item,
    acsc_out_if.source              result,
    input  logic                    cfg_write,
    input  logic [NUM_CHANNELS-1:0] cfg_data
);
    import acsc_pkg::*;

    logic                    evt_valid;
    logic                    evt_ready;
    evt_kind_t               evt_kind;
    logic [CH_W-1:0]         evt_channel;
    logic [SUM_W-1:0]        evt_sum;
    logic [CH_W-1:0]         evt_next;
    logic [NUM_CHANNELS-1:0] evt_mask;

    acsc_core #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .AVG_COUNT    (AVG_COUNT),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .evt_valid   (evt_valid),
        .evt_ready   (evt_ready),
        .evt_kind    (evt_kind),
        .evt_channel (evt_channel),
        .evt_sum     (evt_sum),
        .evt_next    (evt_next),
        .evt_mask    (evt_mask)
    );

    acsc_emit #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .AVG_COUNT    (AVG_COUNT),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .evt_valid   (evt_valid),
        .evt_ready   (evt_ready),
        .evt_kind    (evt_kind),
        .evt_channel (evt_channel),
        .evt_sum     (evt_sum),
        .evt_next    (evt_next),
        .evt_mask    (evt_mask),
        .result      (result)
    );

endmodule

[hw/rtl/acsc_core.sv]
// Accumulator, channel selection and event register of the scanner.
`timescale 1ns / 1ps

module acsc_core #(
    parameter int NUM_CHANNELS = acsc_pkg::ACSC_NUM_CHANNELS,
    parameter int AVG_COUNT    = acsc_pkg::ACSC_AVG_COUNT,
    parameter int SAMPLE_BITS  = acsc_pkg::ACSC_SAMPLE_BITS,
    localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
    localparam int CNT_W = $clog2(AVG_COUNT),
    localparam int SUM_W = SAMPLE_BITS + CNT_W
) (
    input  logic                    clk,
    input  logic                    rst_n,
    acsc_in_if.sink                 item,
    input  logic                    cfg_write,
    input  logic [NUM_CHANNELS-1:0] cfg_data,
    output logic                    evt_valid,
    input  logic                    evt_ready,
    output acsc_pkg::evt_kind_t     evt_kind,
    output logic [CH_W-1:0]         evt_channel,
    output logic [SUM_W-1:0]        evt_sum,
    output logic [CH_W-1:0]         evt_next,
    output logic [NUM_CHANNELS-1:0] evt_mask
);
    import acsc_pkg::*;

    logic [NUM_CHANNELS-1:0] enable_reg;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CH_W-1:0]         chan_reg, chan_next;

    logic                    evt_valid_reg, evt_valid_next;
    evt_kind_t               evt_kind_reg, evt_kind_next;
    logic [CH_W-1:0]         evt_channel_reg, evt_channel_next;
    logic [SUM_W-1:0]        evt_sum_reg, evt_sum_next;
    logic [CH_W-1:0]         evt_next_reg, evt_next_next;
    logic [NUM_CHANNELS-1:0] evt_mask_reg, evt_mask_next;

    logic             accept;
    logic             load_evt;
    logic             block_done;
    logic [SUM_W-1:0] sum_add;
    logic [CH_W-1:0]  rr_next;

    // lowest enabled channel
    function automatic logic [CH_W-1:0] first_enabled(input logic [NUM_CHANNELS-1:0] en);
        logic [CH_W-1:0] res;
        res = '0;
        for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
            if (en[i])
            begin
                res = CH_W'(i);
            end
        end
        return res;
    endfunction

    // first enabled channel after 'from', wrapping; 'from' if none
    function automatic logic [CH_W-1:0] next_enabled(input logic [CH_W-1:0] from,
                                                     input logic [NUM_CHANNELS-1:0] en);
        logic [CH_W-1:0] res;
        logic [CH_W:0]   c;
        res = from;
        for (int k = NUM_CHANNELS; k >= 1; k--) begin
            c = (CH_W + 1)'(from) + (CH_W + 1)'(k);
            if (c >= (CH_W + 1)'(NUM_CHANNELS))
            begin
                c = c - (CH_W + 1)'(NUM_CHANNELS);
            end
            if (en[c[CH_W-1:0]])
            begin
                res = c[CH_W-1:0];
            end
        end
        return res;
    endfunction

    assign accept     = item.valid && item.ready;
    assign item.ready = !evt_valid_reg || evt_ready;
    assign sum_add    = sum_reg + SUM_W'(item.sample);
    assign block_done = (count_reg == CNT_W'(AVG_COUNT - 1));
    assign rr_next    = next_enabled(chan_reg, enable_reg);

    always_comb
    begin
        sum_next         = sum_reg;
        count_next       = count_reg;
        chan_next        = chan_reg;
        load_evt         = 1'b0;
        evt_kind_next    = evt_kind_reg;
        evt_channel_next = evt_channel_reg;
        evt_sum_next     = evt_sum_reg;
        evt_next_next    = evt_next_reg;
        evt_mask_next    = evt_mask_reg;
        if (accept)
        begin
            unique case (item.op)
                OP_SAMPLE:
                begin
                    if (block_done)
                    begin
                        load_evt         = 1'b1;
                        evt_kind_next    = EVT_AVG;
                        evt_channel_next = chan_reg;
                        evt_sum_next     = sum_add;
                        evt_next_next    = rr_next;
                        chan_next        = rr_next;
                        sum_next         = '0;
                        count_next       = '0;
                    end
                    else
                    begin
                        sum_next   = sum_add;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_START:
                begin
                    if (enable_reg != '0)
                    begin
                        chan_next = first_enabled(enable_reg);
                    end
                end
                OP_STOP:
                begin
                    // partial block is kept; one word per enabled channel
                    if (enable_reg != '0)
                    begin
                        load_evt         = 1'b1;
                        evt_kind_next    = EVT_STOP;
                        evt_channel_next = chan_reg;
                        evt_next_next    = chan_reg;
                        evt_mask_next    = enable_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (load_evt)
        begin
            evt_valid_next = 1'b1;
        end
        else if (evt_ready)
        begin
            evt_valid_next = 1'b0;
        end
        else
        begin
            evt_valid_next = evt_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            chan_reg      <= '0;
            evt_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                enable_reg <= cfg_data;
            end
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            chan_reg      <= chan_next;
            evt_valid_reg <= evt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        evt_kind_reg    <= evt_kind_next;
        evt_channel_reg <= evt_channel_next;
        evt_sum_reg     <= evt_sum_next;
        evt_next_reg    <= evt_next_next;
        evt_mask_reg    <= evt_mask_next;
    end

    assign evt_valid   = evt_valid_reg;
    assign evt_kind    = evt_kind_reg;
    assign evt_channel = evt_channel_reg;
    assign evt_sum     = evt_sum_reg;
    assign evt_next    = evt_next_reg;
    assign evt_mask    = evt_mask_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(AVG_COUNT - 1))
        else $error("sample count past block length");

    a_done_event: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.op == OP_SAMPLE && block_done) |=>
            (evt_valid_reg && evt_kind_reg == EVT_AVG))
        else $error("completed block did not post an average event");

    a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(chan_reg) < NUM_CHANNELS)
        else $error("selected channel out of range");

    a_stop_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid_reg && evt_kind_reg == EVT_STOP) |-> (evt_mask_reg != '0))
        else $error("stop event with no channel enabled");

endmodule

[hw/rtl/acsc_emit.sv]
// Result stage: block average divide and stop word sequencing into the output register.
`timescale 1ns / 1ps

module acsc_emit #(
    parameter int NUM_CHANNELS = acsc_pkg::ACSC_NUM_CHANNELS,
    parameter int AVG_COUNT    = acsc_pkg::ACSC_AVG_COUNT,
    parameter int SAMPLE_BITS  = acsc_pkg::ACSC_SAMPLE_BITS,
    localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
    localparam int CNT_W = $clog2(AVG_COUNT),
    localparam int SUM_W = SAMPLE_BITS + CNT_W
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    evt_valid,
    output logic                    evt_ready,
    input  acsc_pkg::evt_kind_t     evt_kind,
    input  logic [CH_W-1:0]         evt_channel,
    input  logic [SUM_W-1:0]        evt_sum,
    input  logic [CH_W-1:0]         evt_next,
    input  logic [NUM_CHANNELS-1:0] evt_mask,
    acsc_out_if.source              result
);
    import acsc_pkg::*;

    localparam bit POW2 = (AVG_COUNT & (AVG_COUNT - 1)) == 0;

    logic                    busy_reg, busy_next;
    logic [NUM_CHANNELS-1:0] rem_reg, rem_next;

    logic                    out_valid_reg, out_valid_next;
    logic [CH_W-1:0]         out_channel_reg, out_channel_next;
    logic [VALUE_W-1:0]      out_value_reg, out_value_next;
    logic [CH_W-1:0]         out_next_reg, out_next_next;
    logic                    out_last_reg, out_last_next;

    logic                    load;
    logic [NUM_CHANNELS-1:0] mask_cur;
    logic [NUM_CHANNELS-1:0] rem_after;
    logic [CH_W-1:0]         pick;
    logic [SAMPLE_BITS-1:0]  quotient;

    generate
        if (POW2)
        begin : g_shift
            assign quotient = evt_sum[SUM_W-1 -: SAMPLE_BITS];
        end
        else
        begin : g_recip
            // exact reciprocal: m = ceil(2^(N+l) / d), q = (x * m) >> (N+l)
            localparam int          SHIFT      = SUM_W + CNT_W;
            localparam int          PW         = 2 * SUM_W + 1;
            localparam logic [63:0] RECIP_FULL =
                ((64'd1 << SHIFT) + 64'(AVG_COUNT) - 64'd1) / 64'(AVG_COUNT);
            logic [PW-1:0] product;
            assign product  = PW'(evt_sum) * PW'(RECIP_FULL[SUM_W:0]);
            assign quotient = product[SHIFT +: SAMPLE_BITS];
        end
    endgenerate

    assign load      = evt_valid && (!out_valid_reg || result.ready);
    assign mask_cur  = busy_reg ? rem_reg : evt_mask;
    assign rem_after = mask_cur & (mask_cur - NUM_CHANNELS'(1));

    always_comb
    begin
        pick = '0;
        for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
            if (mask_cur[i])
            begin
                pick = CH_W'(i);
            end
        end
    end

    always_comb
    begin
        busy_next        = busy_reg;
        rem_next         = rem_reg;
        evt_ready        = 1'b0;
        out_channel_next = out_channel_reg;
        out_value_next   = out_value_reg;
        out_next_next    = out_next_reg;
        out_last_next    = out_last_reg;
        if (load)
        begin
            out_next_next = evt_next;
            unique case (evt_kind)
                EVT_AVG:
                begin
                    evt_ready        = 1'b1;
                    out_channel_next = evt_channel;
                    out_value_next   = VALUE_W'(quotient);
                    out_last_next    = 1'b1;
                end
                EVT_STOP:
                begin
                    evt_ready        = (rem_after == '0);
                    busy_next        = (rem_after != '0);
                    rem_next         = rem_after;
                    out_channel_next = pick;
                    out_value_next   = NO_RESULT;
                    out_last_next    = (rem_after == '0);
                end
                default:
                begin
                end
            endcase
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg         <= rem_next;
        out_channel_reg <= out_channel_next;
        out_value_reg   <= out_value_next;
        out_next_reg    <= out_next_next;
        out_last_reg    <= out_last_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.channel      = out_channel_reg;
    assign result.value        = out_value_reg;
    assign result.next_channel = out_next_reg;
    assign result.last         = out_last_reg;

    a_busy_holds: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (evt_valid && evt_kind == EVT_STOP))
        else $error("stop sequence lost its event");

    a_busy_rem: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg != '0))
        else $error("stop sequence busy with no channel left");

    a_one_pick: assert property (@(posedge clk) disable iff (!rst_n)
        (load && evt_kind == EVT_STOP) |-> $onehot(mask_cur ^ rem_after))
        else $error("stop word did not retire exactly one channel");

    a_stop_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (load && evt_kind == EVT_STOP && rem_after != '0) |=> busy_reg)
        else $error("stop sequence ended early");

endmodule
